// File: src/pbt_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
package pbt_pkg;

    localparam int MAX_PIECES_DEF = 65536;

    localparam int NUM_PIECES_W  = 17;
    localparam int PIECE_BYTES_W = 25;
    localparam int TOTAL_BYTES_W = 40;
    localparam int CFG_DATA_W    = 40;
    localparam int CFG_INDEX_W   = 2;
    localparam int REQ_W         = 2;
    localparam int PIECE_W       = 16;
    localparam int BYTE_IDX_W    = 13;
    localparam int COUNT_W       = 17;
    localparam int PICK_W        = 17;
    localparam int USED_W        = 15;
    localparam int PROD_W        = COUNT_W + PIECE_BYTES_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_MARK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NEED = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCAN = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_PIECES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIECE_BYTES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL_BYTES = 2'd2;

    localparam logic [NUM_PIECES_W-1:0]  NUM_PIECES_RST  = 17'd1;
    localparam logic [PIECE_BYTES_W-1:0] PIECE_BYTES_RST = 25'd262144;
    localparam logic [TOTAL_BYTES_W-1:0] TOTAL_BYTES_RST = 40'd0;

    localparam logic [PICK_W-1:0] PICK_NONE = 17'h1FFFF;

    typedef struct packed {
        logic capture;
        logic update;
        logic mult;
        logic finish;
        logic clear_step;
    } pbt_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic map_reset;
    } pbt_status_t;

endpackage

// File: src/pbt_ctrl.sv
// Request sequencer: map clearing pass, then capture, update, multiply, report.
module pbt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pbt_pkg::pbt_status_t status,
    output pbt_pkg::pbt_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import pbt_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_UPD   = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        if (status.map_reset)
        begin
            // restart the sweep on a new piece count
            state_next = ST_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
                ST_IDLE:  if (start) state_next = ST_UPD;
                ST_UPD:   state_next = ST_MUL;
                ST_MUL:   state_next = ST_OUT;
                ST_OUT:   state_next = ST_IDLE;
                default:  state_next = ST_CLEAR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_OUT);
        end
    end

    always_comb
    begin
        cmd.capture    = (state_reg == ST_IDLE) && start;
        cmd.update     = (state_reg == ST_UPD);
        cmd.mult       = (state_reg == ST_MUL);
        cmd.finish     = (state_reg == ST_OUT);
        cmd.clear_step = (state_reg == ST_CLEAR);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// File: src/pbt_datapath.sv
// Map memory, config registers, completed counter, scan state and byte math.
module pbt_datapath #(
    parameter int MAX_PIECES = pbt_pkg::MAX_PIECES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pbt_pkg::pbt_cmd_t                     cmd,
    output pbt_pkg::pbt_status_t                  status,
    input  logic                                  cfg_we,
    input  logic [pbt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic [pbt_pkg::REQ_W-1:0]             req_type,
    input  logic [pbt_pkg::PIECE_W-1:0]           piece_index,
    input  logic [pbt_pkg::BYTE_IDX_W-1:0]        byte_index,
    input  logic [7:0]                            peer_byte,
    input  logic                                  last_byte,
    output logic                                  needed,
    output logic                                  pick_valid,
    output logic signed [pbt_pkg::PICK_W-1:0]     picked_piece,
    output logic [pbt_pkg::TOTAL_BYTES_W-1:0]     downloaded_bytes,
    output logic [pbt_pkg::TOTAL_BYTES_W-1:0]     left_bytes,
    output logic [pbt_pkg::COUNT_W-1:0]           completed_count
);
    import pbt_pkg::*;

    localparam int MapDepth = MAX_PIECES / 8;
    localparam int AddrW    = (MapDepth > 1) ? $clog2(MapDepth) : 1;

    function automatic logic [2:0] first_pos(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                pos = 3'(7 - i);
            end
        end
        return pos;
    endfunction

    // configuration
    logic [NUM_PIECES_W-1:0]  num_pieces_reg;
    logic [PIECE_BYTES_W-1:0] piece_bytes_reg;
    logic [TOTAL_BYTES_W-1:0] total_bytes_reg;

    // map memory
    logic [7:0]       mem [MapDepth];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AddrW-1:0] clr_addr_reg;

    // captured request
    logic [REQ_W-1:0]      req_reg;
    logic [2:0]            piece_lo_reg;
    logic [BYTE_IDX_W-1:0] sel_reg;
    logic [7:0]            peer_reg;
    logic                  last_reg;
    logic                  in_map_reg;

    // running state
    logic [COUNT_W-1:0] count_reg;
    logic               found_reg;
    logic [PIECE_W-1:0] scan_piece_reg;
    logic [PROD_W-1:0]  prod_reg;

    // result registers
    logic                     needed_reg;
    logic                     pick_valid_reg;
    logic [PICK_W-1:0]        picked_reg;
    logic [TOTAL_BYTES_W-1:0] down_reg;
    logic [TOTAL_BYTES_W-1:0] left_reg;
    logic [COUNT_W-1:0]       completed_reg;

    logic [NUM_PIECES_W:0]  used_sum;
    logic [USED_W-1:0]      used_raw;
    logic [USED_W-1:0]      used;
    logic [BYTE_IDX_W-1:0]  sel_in;
    logic                   in_map_in;
    logic [7:0]             bit_mask;
    logic                   is_mark;
    logic                   is_scan;
    logic                   mark_set;
    logic [7:0]             need_bits;
    logic                   need_any;
    logic                   hit;
    logic                   found_now;
    logic [PIECE_W-1:0]     piece_now;
    logic [TOTAL_BYTES_W-1:0] down_val;

    assign status.map_reset  = cfg_we && (cfg_index == CFG_NUM_PIECES);
    assign status.clear_last = (clr_addr_reg == AddrW'(MapDepth - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pieces_reg  <= NUM_PIECES_RST;
            piece_bytes_reg <= PIECE_BYTES_RST;
            total_bytes_reg <= TOTAL_BYTES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_PIECES:  num_pieces_reg  <= cfg_data[NUM_PIECES_W-1:0];
                CFG_PIECE_BYTES: piece_bytes_reg <= cfg_data[PIECE_BYTES_W-1:0];
                CFG_TOTAL_BYTES: total_bytes_reg <= cfg_data[TOTAL_BYTES_W-1:0];
                default:         ;
            endcase
        end
    end

    // map bytes in use: ceil(num_pieces / 8), capped at the memory depth
    assign used_sum = {1'b0, num_pieces_reg} + (NUM_PIECES_W + 1)'(7);
    assign used_raw = used_sum[NUM_PIECES_W:3];
    assign used     = (32'(used_raw) > MapDepth) ? USED_W'(MapDepth) : used_raw;

    assign sel_in    = (req_type == REQ_MARK) ? piece_index[PIECE_W-1:3] : byte_index;
    assign in_map_in = USED_W'(sel_in) < used;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req_type;
            piece_lo_reg <= piece_index[2:0];
            sel_reg      <= sel_in;
            peer_reg     <= peer_byte;
            last_reg     <= last_byte;
            in_map_reg   <= in_map_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= mem[AddrW'(sel_in)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (status.map_reset)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        bit_mask  = 8'h80 >> piece_lo_reg;
        is_mark   = (req_reg == REQ_MARK);
        is_scan   = (req_reg == REQ_SCAN);
        mark_set  = is_mark && in_map_reg && ((rd_data_reg & bit_mask) == 8'h00);
        need_bits = (in_map_reg && (req_reg == REQ_NEED || is_scan))
                    ? (peer_reg & ~rd_data_reg) : 8'h00;
        need_any  = |need_bits;
        hit       = is_scan && !found_reg && need_any;
        found_now = found_reg || hit;
        piece_now = hit ? {sel_reg, first_pos(need_bits)} : scan_piece_reg;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = 8'h00;
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.update && mark_set)
        begin
            mem_we    = 1'b1;
            mem_waddr = AddrW'(sel_reg);
            mem_wdata = rd_data_reg | bit_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            found_reg      <= 1'b0;
            scan_piece_reg <= '0;
        end
        else if (status.map_reset)
        begin
            count_reg      <= '0;
            found_reg      <= 1'b0;
            scan_piece_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (mark_set)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (is_scan)
            begin
                // a closing byte reports and drops the scan state
                if (last_reg)
                begin
                    found_reg      <= 1'b0;
                    scan_piece_reg <= '0;
                end
                else if (hit)
                begin
                    found_reg      <= 1'b1;
                    scan_piece_reg <= piece_now;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            needed_reg     <= need_any;
            pick_valid_reg <= is_scan && last_reg;
            if (is_scan && last_reg)
            begin
                picked_reg <= found_now ? {1'b0, piece_now} : PICK_NONE;
            end
            else
            begin
                picked_reg <= '0;
            end
        end
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(count_reg) * PROD_W'(piece_bytes_reg);
        end
        if (cmd.finish)
        begin
            down_reg      <= down_val;
            left_reg      <= total_bytes_reg - down_val;
            completed_reg <= count_reg;
        end
    end

    // saturate downloaded bytes at the total size
    assign down_val = (prod_reg > PROD_W'(total_bytes_reg))
                      ? total_bytes_reg : prod_reg[TOTAL_BYTES_W-1:0];

    assign needed           = needed_reg;
    assign pick_valid       = pick_valid_reg;
    assign picked_piece     = $signed(picked_reg);
    assign downloaded_bytes = down_reg;
    assign left_bytes       = left_reg;
    assign completed_count  = completed_reg;

endmodule

// File: src/piece_bitfield_tracker.sv
// Top level of the completed-piece bitmap tracker with first-needed picker.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------------
//  request   | start / busy        | req_type piece_index byte_index peer_byte
//            |                     | last_byte
//  result    | done (one cycle)    | needed pick_valid picked_piece downloaded_bytes
//            |                     | left_bytes completed_count
//  config    | cfg_we              | cfg_index cfg_data
//
// An accepted request holds busy through the update, multiply and output states;
// done is registered from the output state, after the map memory read,
// the read-modify-write of one map byte, and the registered multiply of the
// completed count by the piece length before the saturating subtract.
// After reset, and after every num_pieces write, a clearing pass zeroes the map
// one byte a cycle, all MAX_PIECES/8 bytes (8192 by default), with busy high.
// Results cannot be stalled: done marks each one for a single cycle.
module piece_bitfield_tracker #(
    parameter int MAX_PIECES = pbt_pkg::MAX_PIECES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    output logic                               done,
    input  logic [pbt_pkg::REQ_W-1:0]          req_type,
    input  logic [pbt_pkg::PIECE_W-1:0]        piece_index,
    input  logic [pbt_pkg::BYTE_IDX_W-1:0]     byte_index,
    input  logic [7:0]                         peer_byte,
    input  logic                               last_byte,
    output logic                               needed,
    output logic                               pick_valid,
    output logic signed [pbt_pkg::PICK_W-1:0]  picked_piece,
    output logic [pbt_pkg::TOTAL_BYTES_W-1:0]  downloaded_bytes,
    output logic [pbt_pkg::TOTAL_BYTES_W-1:0]  left_bytes,
    output logic [pbt_pkg::COUNT_W-1:0]        completed_count,
    input  logic                               cfg_we,
    input  logic [pbt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pbt_pkg::*;

    pbt_cmd_t    cmd;
    pbt_status_t status;

    pbt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    pbt_datapath #(
        .MAX_PIECES (MAX_PIECES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .piece_index      (piece_index),
        .byte_index       (byte_index),
        .peer_byte        (peer_byte),
        .last_byte        (last_byte),
        .needed           (needed),
        .pick_valid       (pick_valid),
        .picked_piece     (picked_piece),
        .downloaded_bytes (downloaded_bytes),
        .left_bytes       (left_bytes),
        .completed_count  (completed_count)
    );

endmodule

// File: src/pbt_checker.sv
// Port-level assertions for the tracker, bound to the top level.
module pbt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic                               pick_valid,
    input logic signed [pbt_pkg::PICK_W-1:0]  picked_piece
);

    // a result never follows another in the next cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done high on two cycles in a row");

    // an accepted request holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding busy cycle");

    // no pick reported outside a closing scan byte
    a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pick_valid) |-> (picked_piece == '0))
        else $error("picked_piece nonzero without pick_valid");

endmodule

bind piece_bitfield_tracker pbt_checker u_pbt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .pick_valid   (pick_valid),
    .picked_piece (picked_piece)
);

// File: test/piece_bitfield_tracker_mon.sv
// Result monitor for the piece bitfield tracker: predicts every request and compares results.
`timescale 1ns / 100ps
module piece_bitfield_tracker_mon (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic [pbt_pkg::REQ_W-1:0]           req_type,
    input  logic [pbt_pkg::PIECE_W-1:0]         piece_index,
    input  logic [pbt_pkg::BYTE_IDX_W-1:0]      byte_index,
    input  logic [7:0]                          peer_byte,
    input  logic                                last_byte,
    input  logic                                needed,
    input  logic                                pick_valid,
    input  logic signed [pbt_pkg::PICK_W-1:0]   picked_piece,
    input  logic [pbt_pkg::TOTAL_BYTES_W-1:0]   downloaded_bytes,
    input  logic [pbt_pkg::TOTAL_BYTES_W-1:0]   left_bytes,
    input  logic [pbt_pkg::COUNT_W-1:0]         completed_count,
    input  logic                                cfg_we,
    input  logic [pbt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pbt_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  errors,
    output int                                  outstanding,
    output int                                  results_seen
);
    import pbt_pkg::*;

    localparam int MAP_BYTES   = MAX_PIECES_DEF / 8;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic                     needed;
        logic                     pick_valid;
        logic [PICK_W-1:0]        picked;
        logic [TOTAL_BYTES_W-1:0] down;
        logic [TOTAL_BYTES_W-1:0] left;
        logic [COUNT_W-1:0]       count;
    } tracker_result_t;

    logic [7:0]               have_map [MAP_BYTES];
    logic [COUNT_W-1:0]       have_count;
    logic                     scan_hit;
    logic [PIECE_W-1:0]       scan_first;
    logic [NUM_PIECES_W-1:0]  n_pieces;
    logic [PIECE_BYTES_W-1:0] p_bytes;
    logic [TOTAL_BYTES_W-1:0] t_bytes;
    tracker_result_t          awaited_q [$];
    tracker_result_t          seen_r;
    tracker_result_t          want_r;

    initial begin
        errors       = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    function automatic void wipe_map();
        for (int i = 0; i < MAP_BYTES; i++)
            have_map[i] = '0;
        have_count = '0;
        scan_hit   = 1'b0;
        scan_first = '0;
    endfunction

    function automatic int bytes_in_use();
        int n;
        n = (int'(n_pieces) + 7) / 8;
        return (n > MAP_BYTES) ? MAP_BYTES : n;
    endfunction

    // Apply one request to the shadow map and return the result it should produce.
    function automatic tracker_result_t apply_request(
        logic [REQ_W-1:0]      req,
        logic [PIECE_W-1:0]    piece,
        logic [BYTE_IDX_W-1:0] bidx,
        logic [7:0]            peer,
        logic                  last
    );
        tracker_result_t r;
        int              used;
        int              b;
        int              pos;
        logic [7:0]      fresh;
        logic [7:0]      bitm;
        logic [41:0]     prod;
        r     = '0;
        used  = bytes_in_use();
        fresh = '0;
        if (int'(bidx) < used && (req == REQ_NEED || req == REQ_SCAN))
            fresh = peer & ~have_map[bidx];
        case (req)
            REQ_MARK:
            begin
                b = int'(piece) / 8;
                if (b < used)
                begin
                    bitm = 8'h80 >> piece[2:0];
                    if ((have_map[b] & bitm) == 8'h00)
                    begin
                        have_map[b] = have_map[b] | bitm;
                        have_count  = have_count + 1'b1;
                    end
                end
            end
            REQ_NEED:
            begin
                r.needed = |fresh;
            end
            REQ_SCAN:
            begin
                r.needed = |fresh;
                // keep only the first needed piece since the last closing byte
                if (!scan_hit && fresh != 8'h00)
                begin
                    pos = 0;
                    while (!fresh[7 - pos])
                        pos++;
                    scan_hit   = 1'b1;
                    scan_first = {bidx, 3'(pos)};
                end
                if (last)
                begin
                    r.pick_valid = 1'b1;
                    r.picked     = scan_hit ? {1'b0, scan_first} : PICK_NONE;
                    scan_hit     = 1'b0;
                    scan_first   = '0;
                end
            end
            default:
            begin
            end
        endcase
        prod    = {25'b0, have_count} * {17'b0, p_bytes};
        r.down  = (prod > {2'b0, t_bytes}) ? t_bytes : prod[TOTAL_BYTES_W-1:0];
        r.left  = t_bytes - r.down;
        r.count = have_count;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t mon: result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [TOTAL_BYTES_W-1:0] got,
                               logic [TOTAL_BYTES_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_map();
            n_pieces = NUM_PIECES_RST;
            p_bytes  = PIECE_BYTES_RST;
            t_bytes  = TOTAL_BYTES_RST;
            awaited_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                results_seen++;
                seen_r.needed     = needed;
                seen_r.pick_valid = pick_valid;
                seen_r.picked     = picked_piece;
                seen_r.down       = downloaded_bytes;
                seen_r.left       = left_bytes;
                seen_r.count      = completed_count;
                if (awaited_q.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want_r = awaited_q.pop_front();
                    check_field("needed", seen_r.needed, want_r.needed);
                    check_field("pick_valid", seen_r.pick_valid, want_r.pick_valid);
                    check_field("picked_piece", seen_r.picked, want_r.picked);
                    check_field("downloaded_bytes", seen_r.down, want_r.down);
                    check_field("left_bytes", seen_r.left, want_r.left);
                    check_field("completed_count", seen_r.count, want_r.count);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_PIECES:
                    begin
                        // a new piece count starts from an empty map
                        n_pieces = cfg_data[NUM_PIECES_W-1:0];
                        wipe_map();
                    end
                    CFG_PIECE_BYTES: p_bytes = cfg_data[PIECE_BYTES_W-1:0];
                    CFG_TOTAL_BYTES: t_bytes = cfg_data[TOTAL_BYTES_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (start && !busy)
                awaited_q.push_back(apply_request(req_type, piece_index, byte_index,
                                                  peer_byte, last_byte));
            outstanding <= awaited_q.size();
        end
    end

endmodule

// File: test/piece_bitfield_tracker_tb.sv
// Testbench top for the piece bitfield tracker: clock, reset, request and register stimulus.
`timescale 1ns / 100ps
module piece_bitfield_tracker_tb;
    import pbt_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 275;
    localparam int MAP_BYTES   = MAX_PIECES_DEF / 8;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      start       = 1'b0;
    logic [REQ_W-1:0]          req_type    = '0;
    logic [PIECE_W-1:0]        piece_index = '0;
    logic [BYTE_IDX_W-1:0]     byte_index  = '0;
    logic [7:0]                peer_byte   = '0;
    logic                      last_byte   = 1'b0;
    logic                      cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index   = '0;
    logic [CFG_DATA_W-1:0]     cfg_data    = '0;
    logic                      busy;
    logic                      done;
    logic                      needed;
    logic                      pick_valid;
    logic signed [PICK_W-1:0]  picked_piece;
    logic [TOTAL_BYTES_W-1:0]  downloaded_bytes;
    logic [TOTAL_BYTES_W-1:0]  left_bytes;
    logic [COUNT_W-1:0]        completed_count;

    int errors;
    int outstanding;
    int results_seen;
    int cycles         = 0;
    int sent           = 0;
    int scans_closed   = 0;
    int settings_used  = 0;
    int cur_used       = 1;
    bit gaps_on        = 1'b1;

    always #HALF_PERIOD clk = ~clk;

    piece_bitfield_tracker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .done             (done),
        .req_type         (req_type),
        .piece_index      (piece_index),
        .byte_index       (byte_index),
        .peer_byte        (peer_byte),
        .last_byte        (last_byte),
        .needed           (needed),
        .pick_valid       (pick_valid),
        .picked_piece     (picked_piece),
        .downloaded_bytes (downloaded_bytes),
        .left_bytes       (left_bytes),
        .completed_count  (completed_count),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    piece_bitfield_tracker_mon mon (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .done             (done),
        .req_type         (req_type),
        .piece_index      (piece_index),
        .byte_index       (byte_index),
        .peer_byte        (peer_byte),
        .last_byte        (last_byte),
        .needed           (needed),
        .pick_valid       (pick_valid),
        .picked_piece     (picked_piece),
        .downloaded_bytes (downloaded_bytes),
        .left_bytes       (left_bytes),
        .completed_count  (completed_count),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .errors           (errors),
        .outstanding      (outstanding),
        .results_seen     (results_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Hold one request until the block takes it; start stays high afterwards.
    task automatic send(logic [REQ_W-1:0] req, logic [PIECE_W-1:0] piece,
                        logic [BYTE_IDX_W-1:0] bidx, logic [7:0] peer, logic last);
        while (gaps_on && $urandom_range(0, 99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= req;
        piece_index <= piece;
        byte_index  <= bidx;
        peer_byte   <= peer;
        last_byte   <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (req == REQ_SCAN && last)
            scans_closed++;
    endtask

    // Drop start and drain every outstanding result.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(int np, logic [PIECE_BYTES_W-1:0] pb,
                             logic [TOTAL_BYTES_W-1:0] tot);
        wait_quiet();
        write_reg(CFG_PIECE_BYTES, CFG_DATA_W'(pb));
        write_reg(CFG_TOTAL_BYTES, tot);
        write_reg(CFG_NUM_PIECES, CFG_DATA_W'(np));
        cfg_we <= 1'b0;
        settings_used++;
        cur_used = (np + 7) / 8;
        if (cur_used > MAP_BYTES)
            cur_used = MAP_BYTES;
    endtask

    function automatic logic [7:0] peer_pattern();
        case ($urandom_range(0, 5))
            0, 1:    return 8'($urandom);
            2, 3:    return 8'h80 >> $urandom_range(0, 7);
            4:       return 8'hFF;
            default: return 8'h00;
        endcase
    endfunction

    // Mostly well-formed scans, need checks and marks near the front of the map, some noise.
    task automatic random_traffic(int quota);
        int start_cnt;
        int pick;
        int lim;
        int len;
        int near;
        start_cnt = sent;
        lim  = (cur_used * 8 < 160) ? cur_used * 8 : 160;
        near = (cur_used < 20) ? cur_used : 20;
        while (sent - start_cnt < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send(REQ_MARK,
                     ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, lim - 1))
                                                : 16'($urandom),
                     13'($urandom), 8'($urandom), 1'($urandom));
            else if (pick < 55)
                send(REQ_NEED, 16'($urandom),
                     ($urandom_range(0, 9) < 8) ? 13'($urandom_range(0, near))
                                                : 13'($urandom),
                     peer_pattern(), 1'($urandom));
            else if (pick < 90)
            begin
                len = $urandom_range(1, (cur_used < 12) ? cur_used : 12);
                // run past the end of a small map now and then
                if (cur_used <= 16 && $urandom_range(0, 9) == 0)
                    len = cur_used + $urandom_range(1, 2);
                for (int i = 0; i < len; i++)
                    send(REQ_SCAN, 16'($urandom), 13'(i), peer_pattern(), i == len - 1);
            end
            else if (pick < 95)
                send(REQ_NONE, 16'($urandom), 13'($urandom), 8'($urandom), 1'($urandom));
            else
                send(REQ_SCAN, 16'($urandom), 13'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one piece, so a single map byte is in use
        send(REQ_MARK, 16'd0, 13'd0, 8'h00, 1'b0);
        send(REQ_MARK, 16'd0, 13'd0, 8'h00, 1'b0);
        send(REQ_MARK, 16'd7, 13'd0, 8'h00, 1'b0);
        send(REQ_MARK, 16'd8, 13'd0, 8'h00, 1'b0);
        send(REQ_MARK, 16'hFFFF, 13'h1FFF, 8'hFF, 1'b1);
        send(REQ_NEED, 16'd0, 13'd0, 8'hFF, 1'b0);
        send(REQ_NEED, 16'hFFFF, 13'h1FFF, 8'hFF, 1'b1);
        send(REQ_SCAN, 16'd0, 13'd0, 8'h7F, 1'b1);
        send(REQ_SCAN, 16'd0, 13'd0, 8'h81, 1'b1);
        send(REQ_SCAN, 16'd0, 13'd1, 8'hFF, 1'b1);
        send(REQ_NONE, 16'hFFFF, 13'h1FFF, 8'hFF, 1'b1);
        send(REQ_NEED, 16'd0, 13'd0, 8'h01, 1'b1);

        // small map with saturation at fifteen pieces
        configure(20, 25'd1000, 40'd15000);
        send(REQ_MARK, 16'd11, 13'd0, 8'h00, 1'b0);
        send(REQ_SCAN, 16'd0, 13'd0, 8'h00, 1'b0);
        send(REQ_SCAN, 16'd0, 13'd1, 8'h10, 1'b0);
        send(REQ_SCAN, 16'd0, 13'd2, 8'hF0, 1'b1);
        send(REQ_MARK, 16'd23, 13'd0, 8'h00, 1'b0);
        send(REQ_MARK, 16'd24, 13'd0, 8'h00, 1'b0);
        send(REQ_NEED, 16'd0, 13'd3, 8'hFF, 1'b0);
        random_traffic(PHASE_ITEMS);

        // largest map and total length with 16 MiB pieces, back-to-back requests
        configure(MAX_PIECES_DEF, 25'd16777216, 40'hFF_FFFF_FFFF);
        gaps_on = 1'b0;
        random_traffic(PHASE_ITEMS);
        gaps_on = 1'b1;

        configure(1, 25'd1, 40'd0);
        random_traffic(PHASE_ITEMS);

        configure(100, 25'($urandom_range(1, 16777216)), {8'($urandom), 32'($urandom)});
        random_traffic(PHASE_ITEMS);

        configure(9, 25'd3, 40'd20);
        random_traffic(PHASE_ITEMS);

        configure(64, 25'($urandom_range(1, 16777216)), {8'($urandom), 32'($urandom)});
        random_traffic(PHASE_ITEMS);

        wait_quiet();
        $display("tb: %0d requests under %0d register settings, %0d scans closed",
                 sent, settings_used, scans_closed);
        $display("tb: %0d results compared, %0d mismatches", results_seen, errors);
        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
